// ----- src/adpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared widths, constants and controller/datapath command types for the
// DSP ADPCM decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int POS_W      = 4;
  localparam int COEF_REGS  = 8;
  localparam int CFG_IDX_W  = $clog2(COEF_REGS);
  localparam int CFG_DATA_W = 64;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int ACC_W      = 34;
  localparam int FRAC_BITS  = 11;
  localparam int Q_W        = ACC_W - FRAC_BITS;
  localparam int ROUND_BIAS = 'h400;
  localparam int SAT_HIGH   = 'h7FFF;
  localparam int SAT_LOW    = -'h8000;
  localparam int HDR_POS    = 2;

  typedef struct packed {
    logic load_ctx;
    logic load_hdr;
    logic take_byte;
    logic mul_first;
    logic mul_second;
    logic sel_low;
    logic commit;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic hdr_due;
    logic pos_odd;
  } sts_t;

endpackage

// ----- src/adpcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// adpcm_ctrl
// Sequencer: takes words, walks each kept nibble through the shared
// multiplier and hands finished samples to the result register.
// ----------------------------------------------------------------------------
module adpcm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              action,
  input  logic              take_high,
  input  logic              take_low,
  output logic              result_valid,
  input  logic              result_ready,
  input  adpcm_pkg::sts_t   sts,
  output adpcm_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL0 = 4'b0010,
    ST_MUL1 = 4'b0100,
    ST_SUM  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   pend_low, pend_low_next;
  logic   cur_low, cur_low_next;
  logic   result_valid_next;
  logic   want_high;
  logic   slot_free;

  assign item_ready = (state == ST_IDLE);
  assign want_high  = take_high & ~sts.pos_odd;
  assign slot_free  = ~result_valid | result_ready;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    pend_low_next = pend_low;
    cur_low_next  = cur_low;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (action) begin
            cmd.load_ctx = 1'b1;
          end else if (sts.hdr_due) begin
            cmd.load_hdr = 1'b1;
          end else begin
            cmd.take_byte = 1'b1;
            pend_low_next = take_low;
            cur_low_next  = ~want_high;
            if (want_high | take_low) begin
              state_next = ST_MUL0;
            end
          end
        end
      end
      ST_MUL0: begin
        cmd.mul_first = 1'b1;
        state_next    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_second = 1'b1;
        cmd.sel_low    = cur_low;
        state_next     = ST_SUM;
      end
      ST_SUM: begin
        cmd.last = cur_low | ~pend_low;
        if (slot_free) begin
          cmd.commit = 1'b1;
          if (cmd.last) begin
            state_next = ST_IDLE;
          end else begin
            cur_low_next = 1'b1;
            state_next   = ST_MUL0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pend_low     <= 1'b0;
      cur_low      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pend_low     <= pend_low_next;
      cur_low      <= cur_low_next;
      result_valid <= result_valid_next;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || result_ready))
    else $error("sample committed over an untaken result");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM && result_valid && !result_ready) |=> (state == ST_SUM))
    else $error("sum left while result stalled");

  a_high_then_low: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !cur_low && pend_low) |=> (state == ST_MUL0 && cur_low))
    else $error("low nibble not started after high");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !(cmd.take_byte || cmd.load_ctx || cmd.load_hdr))
    else $error("word taken while busy");

endmodule

// ----- src/adpcm_dp.sv -----
// ----------------------------------------------------------------------------
// adpcm_dp
// Datapath: coefficient registers, decoder context, shared 16x16 multiplier,
// accumulator, floor shift, saturation and the result register.
// ----------------------------------------------------------------------------
module adpcm_dp (
  input  logic                                      clk,
  input  logic                                      rst,
  input  adpcm_pkg::cmd_t                           cmd,
  output adpcm_pkg::sts_t                           sts,
  input  logic [adpcm_pkg::BYTE_W-1:0]              data_byte,
  input  logic signed [adpcm_pkg::SAMPLE_W-1:0]     hist_newest,
  input  logic signed [adpcm_pkg::SAMPLE_W-1:0]     hist_older,
  input  logic [adpcm_pkg::POS_W-1:0]               frame_nibble,
  input  logic                                      cfg_write,
  input  logic [adpcm_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [adpcm_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic signed [adpcm_pkg::SAMPLE_W-1:0]     pcm_sample,
  output logic                                      last_of_item
);

  localparam int SW = adpcm_pkg::SAMPLE_W;
  localparam int AW = adpcm_pkg::ACC_W;
  localparam int QW = adpcm_pkg::Q_W;
  localparam logic signed [QW-1:0] Q_HIGH = QW'(adpcm_pkg::SAT_HIGH);
  localparam logic signed [QW-1:0] Q_LOW  = QW'(adpcm_pkg::SAT_LOW);

  logic [adpcm_pkg::CFG_DATA_W-1:0] coef_word [adpcm_pkg::COEF_REGS];
  logic [adpcm_pkg::BYTE_W-1:0]     header;
  logic [adpcm_pkg::POS_W-1:0]      pos;
  logic [adpcm_pkg::BYTE_W-1:0]     byte_r;
  logic signed [SW-1:0]             y1, y2;
  logic signed [adpcm_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0]             acc;

  logic [adpcm_pkg::CFG_DATA_W-1:0] word_sel;
  logic [2*SW-1:0]                  pair_sel;
  logic signed [SW-1:0]             c0, c1, mul_a, mul_b;
  logic [adpcm_pkg::NIB_W-1:0]      nib;
  logic signed [AW-1:0]             nib_ext, base, total;
  logic signed [QW-1:0]             q;
  logic signed [SW-1:0]             sat;

  assign sts.hdr_due = (pos < adpcm_pkg::POS_W'(adpcm_pkg::HDR_POS));
  assign sts.pos_odd = pos[0];

  assign word_sel = coef_word[header[7:5]];
  assign pair_sel = header[4] ? word_sel[63:32] : word_sel[31:0];
  assign c0       = pair_sel[SW-1:0];
  assign c1       = pair_sel[2*SW-1:SW];
  assign mul_a    = cmd.mul_second ? c1 : c0;
  assign mul_b    = cmd.mul_second ? y2 : y1;

  assign nib     = cmd.sel_low ? byte_r[3:0] : byte_r[7:4];
  assign nib_ext = AW'($signed(nib));
  assign base    = ((nib_ext <<< header[3:0]) <<< adpcm_pkg::FRAC_BITS)
                   + AW'(adpcm_pkg::ROUND_BIAS);

  assign total = acc + AW'(prod);
  assign q     = QW'(total >>> adpcm_pkg::FRAC_BITS);

  always_comb begin
    if (q > Q_HIGH) begin
      sat = SW'(Q_HIGH);
    end else if (q < Q_LOW) begin
      sat = SW'(Q_LOW);
    end else begin
      sat = SW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < adpcm_pkg::COEF_REGS; i++) begin
        coef_word[i] <= '0;
      end
    end else if (cfg_write) begin
      coef_word[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header <= '0;
      pos    <= '0;
      y1     <= '0;
      y2     <= '0;
    end else begin
      if (cmd.load_ctx) begin
        header <= data_byte;
        pos    <= frame_nibble;
        y1     <= hist_newest;
        y2     <= hist_older;
      end else if (cmd.load_hdr) begin
        header <= data_byte;
        pos    <= adpcm_pkg::POS_W'(adpcm_pkg::HDR_POS);
      end else if (cmd.take_byte) begin
        pos <= pos + (pos[0] ? adpcm_pkg::POS_W'(1) : adpcm_pkg::POS_W'(2));
      end
      if (cmd.commit) begin
        y2 <= y1;
        y1 <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      byte_r <= data_byte;
    end
    if (cmd.mul_first || cmd.mul_second) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_second) begin
      acc <= base + AW'(prod);
    end
    if (cmd.commit) begin
      pcm_sample   <= sat;
      last_of_item <= cmd.last;
    end
  end

endmodule

// ----- src/dsp_adpcm_decoder.sv -----
// ----------------------------------------------------------------------------
// dsp_adpcm_decoder
// 4-bit DSP ADPCM decoder, one wave byte per word, up to two samples out.
//
//  channel  ports                                            dir
//  item     item_valid/ready, action, data_byte, take_*,     in
//           hist_newest, hist_older, frame_nibble
//  result   result_valid/ready, pcm_sample, last_of_item     out
//  cfg      cfg_valid/ready, cfg_index, cfg_data             in
//
// Context load or header byte: taken from idle. Wave byte: taken, then each
// kept nibble makes two passes through the shared 16x16 multiplier, then sum.
// Reset clears coefficients, history, header and position; no clearing pass.
// A stalled result holds the sum stage and the input; the next word is taken
// only once the last sample of the current word sits in the result register.
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic                                  action,
  input  logic [adpcm_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                  take_high,
  input  logic                                  take_low,
  input  logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_newest,
  input  logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_older,
  input  logic [adpcm_pkg::POS_W-1:0]           frame_nibble,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [adpcm_pkg::SAMPLE_W-1:0] pcm_sample,
  output logic                                  last_of_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [adpcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adpcm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  adpcm_pkg::cmd_t cmd;
  adpcm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  adpcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .take_high    (take_high),
    .take_low     (take_low),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  adpcm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .data_byte    (data_byte),
    .hist_newest  (hist_newest),
    .hist_older   (hist_older),
    .frame_nibble (frame_nibble),
    .cfg_write    (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pcm_sample   (pcm_sample),
    .last_of_item (last_of_item)
  );

endmodule
